[hw/rtl/pressure_temp_compensation_assert.svh]
// Assertion helpers for the compensation block.
`ifndef PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication
`define PTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptc assertion failed");

`endif

[hw/rtl/ptc_pkg.sv]
`timescale 1ns / 1ps
package ptc_pkg;
	localparam int DW = 64;

	// handshake status of a shared multicycle unit
	typedef struct packed {
		logic busy;
		logic done;
	} ptc_unit_sts_t;
endpackage

[hw/rtl/ptc_mul.sv]
`timescale 1ns / 1ps
// 64x64 -> low 64 product, 16 multiplier bits per cycle.
module ptc_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptc_pkg::DW-1:0]     op_a,
	input  logic [ptc_pkg::DW-1:0]     op_b,
	output logic [ptc_pkg::DW-1:0]     product,
	output ptc_pkg::ptc_unit_sts_t     sts
);
	logic [ptc_pkg::DW-1:0] a_q, b_q, acc_q;
	logic [1:0]             cnt_q;
	logic                   run_q, done_q;
	logic [ptc_pkg::DW+15:0] pp;

	assign pp = a_q * b_q[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + pp[ptc_pkg::DW-1:0];
			a_q   <= {a_q[ptc_pkg::DW-17:0], 16'd0};
			b_q   <= {16'd0, b_q[ptc_pkg::DW-1:16]};
		end
	end

	assign product  = acc_q;
	assign sts.busy = run_q;
	assign sts.done = done_q;
endmodule

[hw/rtl/ptc_div.sv]
`timescale 1ns / 1ps
// Signed 64-bit divide, truncating; restoring, one quotient bit per cycle.
module ptc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ptc_pkg::DW-1:0]     num,
	input  logic [ptc_pkg::DW-1:0]     den,
	output logic [ptc_pkg::DW-1:0]     quot,
	output logic [ptc_pkg::DW-1:0]     rem,
	output ptc_pkg::ptc_unit_sts_t     sts
);
	logic [ptc_pkg::DW-1:0] rem_q, quo_q, dmag_q, quot_q, remo_q;
	logic [5:0]             cnt_q;
	logic                   run_q, fix_q, done_q, qneg_q, rneg_q;
	logic [ptc_pkg::DW:0]   trial;
	logic                   fits;

	assign trial = {rem_q, quo_q[ptc_pkg::DW-1]};
	assign fits  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fix_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			fix_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					run_q <= 1'b0;
					fix_q <= 1'b1;
				end
			end else if (fix_q) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= num[ptc_pkg::DW-1] ? -num : num;
			dmag_q <= den[ptc_pkg::DW-1] ? -den : den;
			qneg_q <= num[ptc_pkg::DW-1] ^ den[ptc_pkg::DW-1];
			rneg_q <= num[ptc_pkg::DW-1];
		end else if (run_q) begin
			rem_q <= fits ? 64'(trial - {1'b0, dmag_q}) : trial[ptc_pkg::DW-1:0];
			quo_q <= {quo_q[ptc_pkg::DW-2:0], fits};
		end else if (fix_q) begin
			quot_q <= qneg_q ? -quo_q : quo_q;
			remo_q <= rneg_q ? -rem_q : rem_q;
		end
	end

	assign quot     = quot_q;
	assign rem      = remo_q;
	assign sts.busy = run_q | fix_q;
	assign sts.done = done_q;
endmodule

[hw/rtl/pressure_temp_compensation.sv]
`timescale 1ns / 1ps
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_stall    kind, raw_sample
// out      out  out_valid/out_stall  result_kind, value, status
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word at a time. A pressure word skips the second divide with a clamped quotient
// and ends at the divisor check with a zero divisor.
// Products run on the shared multiplier (3 on temperature, up to 12 on pressure),
// divides on the 1-bit-per-cycle divider (up to two on pressure).
// in_stall is high from acceptance until the result is in the output register, which
// holds under out_stall while the next word is taken. Reset clears coefficients and state.
`include "pressure_temp_compensation_assert.svh"
module pressure_temp_compensation #(
	parameter int CFG_IW = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [19:0]       raw_sample,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              result_kind,
	output logic signed [31:0] value,
	output logic [1:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [63:0]       cfg_data
);
	localparam logic [CFG_IW-1:0] REG_TEMP  = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_PA    = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_PB    = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_PLAST = CFG_IW'(3);

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_DIVZ = 2'd1;
	localparam logic [1:0] STAT_T0   = 2'd2;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_DONE  = 5'd1;
	localparam logic [4:0] ST_T_D   = 5'd2;
	localparam logic [4:0] ST_T_M1  = 5'd3;
	localparam logic [4:0] ST_T_M2  = 5'd4;
	localparam logic [4:0] ST_T_M3  = 5'd5;
	localparam logic [4:0] ST_T_F1  = 5'd6;
	localparam logic [4:0] ST_T_F2  = 5'd7;
	localparam logic [4:0] ST_P_A   = 5'd8;
	localparam logic [4:0] ST_P_M1  = 5'd9;
	localparam logic [4:0] ST_P_M2  = 5'd10;
	localparam logic [4:0] ST_P_M3  = 5'd11;
	localparam logic [4:0] ST_P_M4  = 5'd12;
	localparam logic [4:0] ST_P_M5  = 5'd13;
	localparam logic [4:0] ST_P_X   = 5'd14;
	localparam logic [4:0] ST_P_M6  = 5'd15;
	localparam logic [4:0] ST_P_M7  = 5'd16;
	localparam logic [4:0] ST_P_CHK = 5'd17;
	localparam logic [4:0] ST_P_D1  = 5'd18;
	localparam logic [4:0] ST_P_Q   = 5'd19;
	localparam logic [4:0] ST_P_M8  = 5'd20;
	localparam logic [4:0] ST_P_M9  = 5'd21;
	localparam logic [4:0] ST_P_D2  = 5'd22;
	localparam logic [4:0] ST_P_CL  = 5'd23;
	localparam logic [4:0] ST_P_M10 = 5'd24;
	localparam logic [4:0] ST_P_M11 = 5'd25;
	localparam logic [4:0] ST_P_M12 = 5'd26;
	localparam logic [4:0] ST_P_FIN = 5'd27;

	localparam logic signed [63:0] Q_LIM = 64'sd1099511627776; // 2^40
	localparam logic signed [63:0] P_LIM = 64'sd68719476736;   // 2^36

	// trunc toward zero by 2^k: bias negatives by 2^k-1, then floor shift
	function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
	                                                 input int k);
		logic signed [63:0] bias;
		bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
		return (x + bias) >>> k;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic [63:0] sx16(input logic [15:0] f);
		return {{48{f[15]}}, f};
	endfunction

	// coefficient registers
	logic [47:0] tc_q;
	logic [63:0] pa_q, pb_q;
	logic [15:0] pl_q;
	logic signed [31:0] fine_q;

	// sequencer state and working registers
	logic [4:0]  state_q;
	logic        kind_q;
	logic [19:0] raw_q;
	logic [1:0]  stat_q;
	logic signed [63:0] d_q, n_q, tmp_q, a_q, aa_q, b_q, a2_q, a3_q, x_q;
	logic signed [63:0] q_q, r_q, p_q, c_q, sum_q;
	logic signed [31:0] res_q;
	logic        mul_wait_q, div_wait_q;

	// output register
	logic        ov_q, ok_q;
	logic signed [31:0] ovl_q;
	logic [1:0]  ost_q;
	logic        load_out;

	logic [63:0] mul_a, mul_b, mul_p, div_n, div_d, div_q, div_r;
	logic        mul_op, div_op, mul_start, div_start;
	ptc_pkg::ptc_unit_sts_t mul_sts, div_sts;
	logic signed [63:0] mp, xs, n5;

	assign mp = $signed(mul_p);
	assign xs = p_q >>> 13;
	assign n5 = (n_q <<< 2) + n_q;

	// operand select of the shared units
	always_comb begin
		mul_op = 1'b1;
		div_op = 1'b0;
		mul_a  = '0;
		mul_b  = '0;
		div_n  = x_q;
		div_d  = a3_q;
		unique case (state_q)
			ST_T_M1:  begin mul_a = d_q;   mul_b = sx16(tc_q[31:16]); end
			ST_T_M2:  begin mul_a = d_q;   mul_b = d_q; end
			ST_T_M3:  begin mul_a = tmp_q; mul_b = sx16(tc_q[47:32]); end
			ST_P_M1:  begin mul_a = a_q;   mul_b = a_q; end
			ST_P_M2:  begin mul_a = aa_q;  mul_b = sx16(pb_q[31:16]); end
			ST_P_M3:  begin mul_a = a_q;   mul_b = sx16(pb_q[15:0]); end
			ST_P_M4:  begin mul_a = aa_q;  mul_b = sx16(pa_q[47:32]); end
			ST_P_M5:  begin mul_a = a_q;   mul_b = sx16(pa_q[31:16]); end
			ST_P_M6:  begin mul_a = x_q >>> 33; mul_b = {48'd0, pa_q[15:0]}; end
			ST_P_M7:  begin mul_a = {31'd0, x_q[32:0]}; mul_b = {48'd0, pa_q[15:0]}; end
			ST_P_M8:  begin mul_a = q_q;   mul_b = 64'd3125; end
			ST_P_M9:  begin mul_a = r_q;   mul_b = 64'd3125; end
			ST_P_M10: begin mul_a = xs;    mul_b = xs; end
			ST_P_M11: begin mul_a = tmp_q; mul_b = sx16(pl_q); end
			ST_P_M12: begin mul_a = p_q;   mul_b = sx16(pb_q[63:48]); end
			ST_P_D1:  begin mul_op = 1'b0; div_op = 1'b1; end
			ST_P_D2:  begin mul_op = 1'b0; div_op = 1'b1; div_n = tmp_q; end
			default:  mul_op = 1'b0;
		endcase
	end

	assign mul_start = mul_op && !mul_wait_q;
	assign div_start = div_op && !div_wait_q;

	ptc_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start),
		.op_a(mul_a), .op_b(mul_b), .product(mul_p), .sts(mul_sts)
	);

	ptc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_n), .den(div_d), .quot(div_q), .rem(div_r), .sts(div_sts)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// result moves into the output register when it is free or being drained
	assign load_out = (state_q == ST_DONE) && (!ov_q || !out_stall);

	// config writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tc_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			pl_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_TEMP)  tc_q <= cfg_data[47:0];
			if (cfg_index == REG_PA)    pa_q <= cfg_data;
			if (cfg_index == REG_PB)    pb_q <= cfg_data;
			if (cfg_index == REG_PLAST) pl_q <= cfg_data[15:0];
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mul_wait_q <= 1'b0;
			div_wait_q <= 1'b0;
			ov_q       <= 1'b0;
			fine_q     <= '0;
		end else begin
			if (mul_start) mul_wait_q <= 1'b1;
			else if (mul_sts.done) mul_wait_q <= 1'b0;
			if (div_start) div_wait_q <= 1'b1;
			else if (div_sts.done) div_wait_q <= 1'b0;
			ov_q <= load_out || (ov_q && out_stall);

			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= kind ? ST_P_A : ST_T_D;
				ST_T_D:  state_q <= ST_T_M1;
				ST_T_M1: if (mul_sts.done) state_q <= ST_T_M2;
				ST_T_M2: if (mul_sts.done) state_q <= ST_T_M3;
				ST_T_M3: if (mul_sts.done) state_q <= ST_T_F1;
				ST_T_F1: begin
					fine_q  <= 32'(trunc_shr(n_q, 34));
					state_q <= ST_T_F2;
				end
				ST_T_F2:  state_q <= ST_DONE;
				ST_P_A:   state_q <= ST_P_M1;
				ST_P_M1:  if (mul_sts.done) state_q <= ST_P_M2;
				ST_P_M2:  if (mul_sts.done) state_q <= ST_P_M3;
				ST_P_M3:  if (mul_sts.done) state_q <= ST_P_M4;
				ST_P_M4:  if (mul_sts.done) state_q <= ST_P_M5;
				ST_P_M5:  if (mul_sts.done) state_q <= ST_P_X;
				ST_P_X:   state_q <= ST_P_M6;
				ST_P_M6:  if (mul_sts.done) state_q <= ST_P_M7;
				ST_P_M7:  if (mul_sts.done) state_q <= ST_P_CHK;
				ST_P_CHK: state_q <= (a3_q == 64'sd0) ? ST_DONE : ST_P_D1;
				ST_P_D1:  if (div_sts.done) state_q <= ST_P_Q;
				ST_P_Q: begin
					if (q_q > Q_LIM || q_q < -Q_LIM) state_q <= ST_P_CL;
					else state_q <= ST_P_M8;
				end
				ST_P_M8:  if (mul_sts.done) state_q <= ST_P_M9;
				ST_P_M9:  if (mul_sts.done) state_q <= ST_P_D2;
				ST_P_D2:  if (div_sts.done) state_q <= ST_P_CL;
				ST_P_CL:  state_q <= ST_P_M10;
				ST_P_M10: if (mul_sts.done) state_q <= ST_P_M11;
				ST_P_M11: if (mul_sts.done) state_q <= ST_P_M12;
				ST_P_M12: if (mul_sts.done) state_q <= ST_P_FIN;
				ST_P_FIN: state_q <= ST_DONE;
				ST_DONE:  if (load_out) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= kind;
				raw_q  <= raw_sample;
			end
			ST_T_D: begin
				d_q    <= $signed({44'd0, raw_q}) - $signed({44'd0, tc_q[15:0], 4'd0});
				stat_q <= STAT_OK;
			end
			ST_T_M1: if (mul_sts.done) n_q <= mp <<< 20;
			ST_T_M2: if (mul_sts.done) tmp_q <= mp;
			ST_T_M3: if (mul_sts.done) n_q <= n_q + mp;
			ST_T_F1: tmp_q <= n5;
			ST_T_F2: res_q <= sat32(trunc_shr(tmp_q, 42));
			ST_P_A: begin
				a_q    <= 64'(fine_q) - 64'sd128000;
				stat_q <= (fine_q == 32'sd0) ? STAT_T0 : STAT_OK;
			end
			ST_P_M1: if (mul_sts.done) aa_q <= mp;
			ST_P_M2: if (mul_sts.done) b_q <= mp;
			ST_P_M3: if (mul_sts.done)
				b_q <= b_q + (mp <<< 17) + $signed(sx16(pa_q[63:48]) << 35);
			ST_P_M4: if (mul_sts.done) a2_q <= mp >>> 8;
			ST_P_M5: if (mul_sts.done) a2_q <= a2_q + (mp <<< 12);
			ST_P_X:  x_q <= (64'sd1 <<< 47) + a2_q;
			ST_P_M6: if (mul_sts.done) a3_q <= mp;
			ST_P_M7: if (mul_sts.done) a3_q <= a3_q + (mp >>> 33);
			ST_P_CHK: begin
				x_q <= $signed((64'd1048576 - {44'd0, raw_q}) << 31) - b_q;
				if (a3_q == 64'sd0) begin
					stat_q <= STAT_DIVZ;
					res_q  <= '0;
				end
			end
			ST_P_D1: if (div_sts.done) begin
				q_q <= $signed(div_q);
				r_q <= $signed(div_r);
			end
			ST_P_Q: begin
				if (q_q > Q_LIM) p_q <= P_LIM;
				else if (q_q < -Q_LIM) p_q <= -P_LIM;
			end
			ST_P_M8:  if (mul_sts.done) p_q <= mp;
			ST_P_M9:  if (mul_sts.done) tmp_q <= mp;
			ST_P_D2:  if (div_sts.done) p_q <= p_q + $signed(div_q);
			ST_P_CL: begin
				if (p_q > P_LIM) p_q <= P_LIM;
				else if (p_q < -P_LIM) p_q <= -P_LIM;
			end
			ST_P_M10: if (mul_sts.done) tmp_q <= mp;
			ST_P_M11: if (mul_sts.done) c_q <= mp >>> 25;
			ST_P_M12: if (mul_sts.done) sum_q <= p_q + c_q + (mp >>> 19);
			ST_P_FIN:
				res_q <= sat32((sum_q >>> 8) + $signed(sx16(pb_q[47:32]) << 4));
			ST_DONE: if (load_out) begin
				ok_q  <= kind_q;
				ovl_q <= res_q;
				ost_q <= stat_q;
			end
			default: ;
		endcase
	end

	assign out_valid   = ov_q;
	assign result_kind = ok_q;
	assign value       = ovl_q;
	assign status      = ost_q;

	`PTC_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, state_q != ST_IDLE)
	`PTC_ASSERT_IMP(a_mul_tracked, mul_wait_q, mul_sts.busy || mul_sts.done)
	`PTC_ASSERT_IMP(a_divz_zero, ov_q && ost_q == STAT_DIVZ, ovl_q == 32'sd0 && ok_q)
	`PTC_ASSERT_IMP(a_temp_ok, ov_q && !ok_q, ost_q == STAT_OK)
endmodule

[tb/sv/ptc_tb_pkg.sv]
`timescale 1ns / 1ps
package ptc_tb_pkg;
	// sample kind
	localparam logic KIND_TEMP  = 1'b0;
	localparam logic KIND_PRESS = 1'b1;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_DIVZERO = 2'd1;
	localparam logic [1:0] ST_FTZERO  = 2'd2;

	// register map
	localparam logic [3:0] REG_TEMP_COEFFS = 4'd0;
	localparam logic [3:0] REG_PRESS_A     = 4'd1;
	localparam logic [3:0] REG_PRESS_B     = 4'd2;
	localparam logic [3:0] REG_PRESS_LAST  = 4'd3;
	localparam logic [3:0] REG_UNUSED      = 4'd9;
endpackage

[tb/sv/ptc_checker.sv]
`timescale 1ns / 1ps
module ptc_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic              kind,
	input  logic [19:0]       raw_sample,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              result_kind,
	input  logic signed [31:0] value,
	input  logic [1:0]        status,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [3:0]        cfg_index,
	input  logic [63:0]       cfg_data,
	output int                errors,
	output int                pending,
	output int                n_temp,
	output int                n_press,
	output int                n_divzero,
	output int                n_ftzero
);
	typedef struct {
		logic              kind;
		logic signed [31:0] value;
		logic [1:0]        status;
	} comp_result_t;

	comp_result_t expected_q[$];

	logic [47:0] temp_coeffs;
	logic [63:0] press_a, press_b;
	logic [15:0] press_last;
	int          fine_temp;

	function automatic longint s16(logic [15:0] f);
		return longint'($signed(f));
	endfunction

	function automatic longint trunc_shr(longint x, int k);
		longint unsigned m;
		m = (x < 0) ? longint'(-x) : x;
		m = m >> k;
		return (x < 0) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [31:0] sat32(longint x);
		if (x > 64'sd2147483647) return 32'sh7fffffff;
		if (x < -64'sd2147483648) return 32'sh80000000;
		return x[31:0];
	endfunction

	// temperature: updates fine temperature, returns 0.01 degC
	function automatic comp_result_t compensate_temp(logic [19:0] raw);
		comp_result_t r;
		longint d, num;
		d = longint'(raw) - 16 * longint'(temp_coeffs[15:0]);
		num = d * s16(temp_coeffs[31:16]) * 1048576 + d * d * s16(temp_coeffs[47:32]);
		fine_temp = int'(trunc_shr(num, 34));
		r.kind = ptc_tb_pkg::KIND_TEMP;
		r.value = sat32(trunc_shr(num * 5, 42));
		r.status = ptc_tb_pkg::ST_OK;
		return r;
	endfunction

	// pressure: Pa as Q24.8 from the stored fine temperature
	function automatic comp_result_t compensate_press(logic [19:0] raw);
		comp_result_t r;
		longint a, b, x, xh, xl, p, q, rem, c, e, lim;
		lim = 64'sd1 <<< 36;
		r.kind = ptc_tb_pkg::KIND_PRESS;
		r.status = (fine_temp == 0) ? ptc_tb_pkg::ST_FTZERO : ptc_tb_pkg::ST_OK;
		a = longint'(fine_temp) - 128000;
		b = a * a * s16(press_b[31:16]) + a * s16(press_b[15:0]) * 131072
			+ s16(press_a[63:48]) * (64'sd1 <<< 35);
		a = ((a * a * s16(press_a[47:32])) >>> 8) + a * s16(press_a[31:16]) * 4096;
		x = (64'sd1 <<< 47) + a;
		xh = x >>> 33;
		xl = x - xh * (64'sd1 <<< 33);
		a = xh * longint'(press_a[15:0]) + ((xl * longint'(press_a[15:0])) >>> 33);
		if (a == 0) begin
			r.status = ptc_tb_pkg::ST_DIVZERO;
			r.value = '0;
			return r;
		end
		x = (1048576 - longint'(raw)) * (64'sd1 <<< 31) - b;
		q = x / a;
		rem = x % a;
		if (q > (64'sd1 <<< 40)) p = lim;
		else if (q < -(64'sd1 <<< 40)) p = -lim;
		else p = q * 3125 + (rem * 3125) / a;
		if (p > lim) p = lim;
		if (p < -lim) p = -lim;
		x = p >>> 13;
		c = (s16(press_last) * x * x) >>> 25;
		e = (s16(press_b[63:48]) * p) >>> 19;
		r.value = sat32(((p + c + e) >>> 8) + s16(press_b[47:32]) * 16);
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		comp_result_t w;
		if (!arst_n) begin
			errors = 0; n_temp = 0; n_press = 0; n_divzero = 0; n_ftzero = 0;
			temp_coeffs = '0; press_a = '0; press_b = '0; press_last = '0; fine_temp = 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ptc_tb_pkg::REG_TEMP_COEFFS: temp_coeffs = cfg_data[47:0];
					ptc_tb_pkg::REG_PRESS_A:     press_a = cfg_data;
					ptc_tb_pkg::REG_PRESS_B:     press_b = cfg_data;
					ptc_tb_pkg::REG_PRESS_LAST:  press_last = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_q.push_back(kind == ptc_tb_pkg::KIND_TEMP
					? compensate_temp(raw_sample) : compensate_press(raw_sample));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected result word", 64'(value), 64'd0);
				end else begin
					w = expected_q.pop_front();
					if (result_kind !== w.kind)
						report("result_kind", 64'(result_kind), 64'(w.kind));
					if (value !== w.value) report("value", 64'(value), 64'(w.value));
					if (status !== w.status) report("status", 64'(status), 64'(w.status));
					if (w.kind == ptc_tb_pkg::KIND_TEMP) n_temp++; else n_press++;
					if (w.status == ptc_tb_pkg::ST_DIVZERO) n_divzero++;
					if (w.status == ptc_tb_pkg::ST_FTZERO) n_ftzero++;
				end
			end
		end
		pending = expected_q.size();
	end
endmodule

[tb/sv/tb_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
module tb_pressure_temp_compensation;
	// cycles with no handshake on any channel before giving up;
	// a pressure word takes the longest, and stalls add to it
	localparam int STALL_LIMIT = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              kind = ptc_tb_pkg::KIND_TEMP;
	logic [19:0]       raw_sample = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              result_kind;
	logic signed [31:0] value;
	logic [1:0]        status;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [3:0]        cfg_index = '0;
	logic [63:0]       cfg_data = '0;

	int errors, pending, n_temp, n_press, n_divzero, n_ftzero;
	int idle_cnt;
	bit no_idle = 1'b0;   // set for the stretch with back-to-back traffic

	always #5 clk = ~clk;

	pressure_temp_compensation dut (.*);

	ptc_checker chk (.*);

	// output side: stall ~26% of cycles unless in the quiet stretch
	always @(posedge clk)
		out_stall <= !no_idle && ($urandom_range(99) < 26);

	// watchdog: any handshake restarts the count
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= STALL_LIMIT) begin
			$display("watchdog expired, %0d words still expected", pending);
			$display("status: fail");
			$finish;
		end
	end

	// valid stays up for back-to-back writes; the caller drops it after the last
	task automatic write_reg(logic [3:0] idx, logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// one sample word; input side idles ~26% of the time before it
	task automatic send_sample(logic k, logic [19:0] raw);
		if (!no_idle && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		raw_sample <= raw;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// drain: every expected word back, then a short settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic load_coeffs(logic [47:0] tc, logic [63:0] pa, logic [63:0] pb,
			logic [15:0] p9);
		drain();
		write_reg(ptc_tb_pkg::REG_TEMP_COEFFS, {16'hdead, tc});  // upper bits ignored
		write_reg(ptc_tb_pkg::REG_PRESS_A, pa);
		write_reg(ptc_tb_pkg::REG_PRESS_B, pb);
		write_reg(ptc_tb_pkg::REG_PRESS_LAST, {48'hffff_0000_1234, p9});
		if ($urandom_range(3) == 0) write_reg(ptc_tb_pkg::REG_UNUSED, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [19:0] rand_raw();
		case ($urandom_range(9)) inside
			0: return 20'h00000;
			1: return 20'hfffff;
			2, 3: return 20'd519888 + 20'($urandom_range(65535)) - 20'd32768;
			4, 5: return 20'd415148 + 20'($urandom_range(65535)) - 20'd32768;
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] jitter(logic [15:0] base);
		return base + 16'($urandom_range(255)) - 16'd128;
	endfunction

	initial begin
		logic [47:0] tc;
		logic [63:0] pa, pb;
		int n;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: P1 = 0 makes the divisor zero
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd0);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'hfffff);

		// typical sensor calibration; pressure first while fine temperature is 0
		load_coeffs({16'hfc18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hd641, 16'd36477},
			{16'hc6f8, 16'd15500, 16'hfff9, 16'd140}, 16'd6000);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd415148);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'd519888);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd415148);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd0);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'hfffff);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'd0);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'hfffff);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd300000);

		// T2 = T3 = 0 gives fine temperature 0 with a valid divisor
		load_coeffs({16'd0, 16'd0, 16'd27504},
			{16'd2855, 16'd3024, 16'hd641, 16'd36477}, 64'h1234_5678_9abc_def0, 16'd0);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'd123456);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd415148);

		// all-ones, most-negative and most-positive coefficient extremes; drives clamping
		load_coeffs('1, '1, '1, 16'hffff);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'hfffff);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'hfffff);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd0);
		load_coeffs({3{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'd0);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'd0);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'h80000);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'hfffff);
		load_coeffs({3{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 16'h7fff);
		send_sample(ptc_tb_pkg::KIND_TEMP, 20'h7ffff);
		send_sample(ptc_tb_pkg::KIND_PRESS, 20'h12345);

		// random phases: mostly calibrations near a real part, some fully random
		for (int ph = 0; ph < 10; ph++) begin
			if (ph % 3 == 2) begin
				tc = 48'({$urandom, $urandom});
				pa = {$urandom, $urandom};
				pb = {$urandom, $urandom};
			end else begin
				tc = {jitter(16'hfc18), jitter(16'd26435), jitter(16'd27504)};
				pa = {jitter(16'd2855), jitter(16'd3024), jitter(16'hd641), jitter(16'd36477)};
				pb = {jitter(16'hc6f8), jitter(16'd15500), jitter(16'hfff9), jitter(16'd140)};
			end
			load_coeffs(tc, pa, pb, (ph % 3 == 2) ? 16'($urandom) : jitter(16'd6000));
			no_idle = (ph == 5);
			n = 100;
			for (int i = 0; i < n; i++) begin
				// temperature then a burst of pressure, like a real polling loop
				if (i % 4 == 0 || $urandom_range(9) == 0)
					send_sample(ptc_tb_pkg::KIND_TEMP, rand_raw());
				else
					send_sample(ptc_tb_pkg::KIND_PRESS, rand_raw());
			end
		end
		no_idle = 1'b0;
		drain();
		repeat (300) @(posedge clk);

		$display("checked %0d temperature and %0d pressure words", n_temp, n_press);
		$display("%0d with zero divisor, %0d with fine temperature zero", n_divzero, n_ftzero);
		if (errors == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
